/* hdl/task_queue_fifo_lifo_sorted_macros.svh */
// Assertion macros for the task queue block.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef TASK_QUEUE_FIFO_LIFO_SORTED_MACROS_SVH
`define TASK_QUEUE_FIFO_LIFO_SORTED_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("task queue check failed");
// next-cycle implication
`define TQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("task queue check failed");
`else
`define TQ_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define TQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* hdl/tqfls_pkg.sv */
// Package for the task queue: command and status codes, entry type, sequencer states, priority function.
// No dependencies.
`timescale 1ns / 1ps

package tqfls_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int IN_W      = 40;  // func 3 + tag 16 + duration 16, padded to bytes
    localparam int OUT_W     = 48;

    typedef enum logic [2:0] {
        FN_APPEND   = 3'd0,
        FN_INSERT   = 3'd1,
        FN_CANCEL   = 3'd2,
        FN_POP_HEAD = 3'd3,
        FN_POP_TAIL = 3'd4,
        FN_LOOKUP   = 3'd5,
        FN_CLEAR    = 3'd6,
        FN_NOP      = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_INVALID  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  prio;
        logic [15:0] duration;
        logic [15:0] tag;
    } t_entry;

    // min(d / 10, 5) as a compare ladder
    function automatic logic [2:0] prio_of(input logic [15:0] d);
        logic [2:0] p;
        if (d >= 16'd50)      p = 3'd5;
        else if (d >= 16'd40) p = 3'd4;
        else if (d >= 16'd30) p = 3'd3;
        else if (d >= 16'd20) p = 3'd2;
        else if (d >= 16'd10) p = 3'd1;
        else                  p = 3'd0;
        return p;
    endfunction

endpackage

/* hdl/tqfls_mem.sv */
// Entry store of the task queue: one write port, one registered read port.
// Depends on tqfls_pkg for the entry type.
`timescale 1ns / 1ps

module tqfls_mem
    import tqfls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/task_queue_fifo_lifo_sorted.sv */
// Bounded ordered task queue: sequencer plus an entry store with one write and one read port.
// Depends on tqfls_pkg, tqfls_mem and the assertion macro header.
//
// Usage
//  - Slave channel (i_s_*): one command per transaction. tdata carries func,
//    task_id and task_duration. Commands: append, sorted insert, cancel,
//    pop head, pop tail, lookup, clear, and a no-op code.
//  - Master channel (o_m_*): exactly one result transaction per command:
//    status, entry fields, 1-based position and the entry count afterwards.
//  - Scan: a single tag/duration comparator walks the store one entry at a
//    time (read issue, then compare on registered read data); removal and
//    sorted insert then move entries one at a time through the same store
//    ports.
//  - o_s_tready is high only while the sequencer is idle; one command at a time.
//  - The result sits in an output register, so a new command is taken while a
//    previous result still waits; a stalled receiver only holds the block
//    once a second result is ready to be handed over.
//  - Reset empties the queue (entry count zero); store contents are not cleared.
`timescale 1ns / 1ps
`include "task_queue_fifo_lifo_sorted_macros.svh"

module task_queue_fifo_lifo_sorted
    import tqfls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // func[2:0], task_id[18:3], task_duration[34:19]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status[2:0], out_id[18:3], out_duration[34:19],
                                          // out_priority[37:35], position[42:38],
                                          // entry_count[47:43]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill,  n_fill;
    logic [CW-1:0]     r_idx,   n_idx;   // scan / removal pointer, insert point
    logic [CW-1:0]     r_j,     n_j;     // upward move pointer for insert
    logic              r_m_valid, n_m_valid;

    // command and result payload
    t_func             r_func,  n_func;
    logic [15:0]       r_tag,   n_tag;
    logic [15:0]       r_dur,   n_dur;
    t_status           r_status, n_status;
    t_entry            r_ent,   n_ent;
    logic [4:0]        r_pos,   n_pos;
    logic [OUT_W-1:0]  r_m_data, n_m_data;

    // store port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    t_entry            mem_wdata;
    t_entry            mem_q;

    // decoded input transaction
    t_func             in_func;
    logic [15:0]       in_tag;
    logic [15:0]       in_dur;
    logic              s_acc;

    // helpers
    t_entry            new_ent;
    logic              is_pop;
    logic              hit;
    logic [CW:0]       idx_inc;
    logic [31:0]       pos_wide;
    logic [31:0]       cnt_wide;

    assign in_func = t_func'(i_s_tdata[2:0]);
    assign in_tag  = i_s_tdata[18:3];
    assign in_dur  = i_s_tdata[34:19];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign new_ent  = '{prio: prio_of(r_dur), duration: r_dur, tag: r_tag};
    assign is_pop   = (r_func == FN_POP_HEAD) || (r_func == FN_POP_TAIL);
    // shared comparator: duration order for insert, tag match for append/cancel/lookup; pops always hit
    assign hit      = is_pop ||
                      ((r_func == FN_INSERT) ? (mem_q.duration > r_dur)
                                             : (mem_q.tag == r_tag));
    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign pos_wide = 32'(idx_inc);
    assign cnt_wide = 32'(r_fill);

    tqfls_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_j       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_j       <= n_j;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_tag    <= n_tag;
        r_dur    <= n_dur;
        r_status <= n_status;
        r_ent    <= n_ent;
        r_pos    <= n_pos;
        r_m_data <= n_m_data;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_j       = r_j;
        n_func    = r_func;
        n_tag     = r_tag;
        n_dur     = r_dur;
        n_status  = r_status;
        n_ent     = r_ent;
        n_pos     = r_pos;
        n_m_data  = r_m_data;
        n_m_valid = r_m_valid && !i_m_tready;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_q;
        mem_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_func   = in_func;
                    n_tag    = in_tag;
                    n_dur    = in_dur;
                    n_status = ST_OK;
                    n_ent    = '0;
                    n_pos    = '0;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    case (in_func)
                        FN_APPEND, FN_CANCEL, FN_LOOKUP: begin
                            if (in_tag == 16'd0) n_status = ST_INVALID;
                            else                 n_state  = S_SCAN;
                        end
                        FN_INSERT: begin
                            if (in_tag == 16'd0)                 n_status = ST_INVALID;
                            else if (r_fill >= CW'(DEPTH))       n_status = ST_FULL;
                            else                                 n_state  = S_SCAN;
                        end
                        FN_POP_HEAD: begin
                            if (r_fill == '0) n_status = ST_EMPTY;
                            else              n_state  = S_SCAN;
                        end
                        FN_POP_TAIL: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = CW'(r_fill - 1'b1);
                                n_state = S_SCAN;
                            end
                        end
                        FN_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_idx >= r_fill) begin
                    // end of list reached without a hit
                    case (r_func)
                        FN_APPEND: begin
                            if (r_fill >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_fill[AW-1:0];
                                mem_wdata = new_ent;
                                n_fill    = CW'(r_fill + 1'b1);
                            end
                            n_state = S_DONE;
                        end
                        FN_INSERT: begin
                            n_j     = r_fill;
                            n_state = S_UP_RD;
                        end
                        default: begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_DONE;
                        end
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end

            S_CMP: begin
                if (hit) begin
                    case (r_func)
                        FN_APPEND: begin
                            n_status = ST_DUP;
                            n_state  = S_DONE;
                        end
                        FN_INSERT: begin
                            n_j     = r_fill;
                            n_state = S_UP_RD;
                        end
                        FN_LOOKUP: begin
                            n_ent   = mem_q;
                            n_pos   = pos_wide[4:0];
                            n_state = S_DONE;
                        end
                        FN_CANCEL: begin
                            n_ent   = mem_q;
                            n_pos   = pos_wide[4:0];
                            n_state = S_SH_RD;
                        end
                        default: begin
                            // pops: same removal as cancel, no position
                            n_ent   = mem_q;
                            n_state = S_SH_RD;
                        end
                    endcase
                end else begin
                    n_idx   = idx_inc[CW-1:0];
                    n_state = S_SCAN;
                end
            end

            // close the gap: entry idx+1 moves down to idx
            S_SH_RD: begin
                if (idx_inc < {1'b0, r_fill}) begin
                    mem_raddr = idx_inc[AW-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_fill  = CW'(r_fill - 1'b1);
                    n_state = S_DONE;
                end
            end

            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_q;
                n_idx     = idx_inc[CW-1:0];
                n_state   = S_SH_RD;
            end

            // open a gap at idx: entries move up one from the tail
            S_UP_RD: begin
                if (r_j == r_idx) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j[AW-1:0];
                    mem_wdata = new_ent;
                    n_fill    = CW'(r_fill + 1'b1);
                    n_state   = S_DONE;
                end else begin
                    mem_raddr = AW'(r_j - 1'b1);
                    n_state   = S_UP_WR;
                end
            end

            S_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[AW-1:0];
                mem_wdata = mem_q;
                n_j       = CW'(r_j - 1'b1);
                n_state   = S_UP_RD;
            end

            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {cnt_wide[4:0], r_pos, r_ent.prio,
                                 r_ent.duration, r_ent.tag, r_status};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // checks
    `TQ_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH))
    `TQ_ASSERT_IMPLY(a_insert_room, i_clk, i_rst_n, r_state == S_UP_RD, r_fill < CW'(DEPTH))
    `TQ_ASSERT_IMPLY(a_shift_in_list, i_clk, i_rst_n, r_state == S_SH_WR,
                     (idx_inc < {1'b0, r_fill}))
    `TQ_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, s_acc && (in_func == FN_CLEAR),
                    r_fill == '0)

endmodule
